### rtl/binary_to_radix_digit_string_assert.svh
// Assertion macros for the radix conversion block.
// Every use is sampled on clk_i and held off while rst_ni is low.
`ifndef BINARY_TO_RADIX_DIGIT_STRING_ASSERT_SVH
`define BINARY_TO_RADIX_DIGIT_STRING_ASSERT_SVH

`ifndef ASSERT_OFF
`define B2R_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define B2R_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);
`else
`define B2R_ASSERT(lbl, prop, msg)
`define B2R_ASSERT_IMPL(lbl, pre, post, msg)
`endif

`endif

### rtl/b2r_pkg.sv
package b2r_pkg;

  // Field widths and sizing
  localparam int VALUE_WIDTH = 63;
  localparam int INPUT_WIDTH = 63;
  localparam int DIGIT_SLOTS = 64;
  localparam int RADIX_W     = 6;
  localparam int CHAR_W      = 7;
  localparam int IDX_W       = $clog2(DIGIT_SLOTS);
  localparam int CNT_W       = $clog2(DIGIT_SLOTS + 1);
  localparam int STEP_W      = $clog2(VALUE_WIDTH);

  // Radix bounds and character codes
  localparam logic [RADIX_W-1:0] RADIX_MIN     = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX     = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] DEC_LIMIT     = RADIX_W'(9);
  localparam logic [RADIX_W-1:0] DEC_DIGITS    = RADIX_W'(10);
  localparam logic [CHAR_W-1:0]  ASCII_ZERO    = CHAR_W'(8'h30);
  localparam logic [CHAR_W-1:0]  ASCII_LOWER_A = CHAR_W'(8'h61);

  // Divider request and response
  typedef struct packed {
    logic                   start;
    logic [VALUE_WIDTH-1:0] dividend;
    logic [RADIX_W-1:0]     divisor;
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic [VALUE_WIDTH-1:0] quotient;
    logic [RADIX_W-1:0]     remainder;
  } div_rsp_t;

  // Digit value to ASCII: 0-9 then a-z
  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d <= DEC_LIMIT) begin
      c = ASCII_ZERO + CHAR_W'(d);
    end else begin
      c = ASCII_LOWER_A + CHAR_W'(d - DEC_DIGITS);
    end
    return c;
  endfunction

endpackage

### rtl/b2r_div.sv
// Restoring divider, one quotient bit per cycle.
module b2r_div import b2r_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [STEP_W-1:0]      step_q, step_d;
  logic [VALUE_WIDTH-1:0] acc_q, acc_d;
  logic [RADIX_W-1:0]     rem_q, rem_d;
  logic [RADIX_W-1:0]     div_q, div_d;
  logic [RADIX_W:0]       trial;
  logic                   fits;

  // One shift-compare-subtract step
  assign trial = {rem_q, acc_q[VALUE_WIDTH-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = STEP_W'(VALUE_WIDTH - 1);
      acc_d  = req_i.dividend;
      rem_d  = '0;
      div_d  = req_i.divisor;
    end else if (busy_q) begin
      acc_d = {acc_q[VALUE_WIDTH-2:0], fits};
      rem_d = fits ? RADIX_W'(trial - {1'b0, div_q}) : trial[RADIX_W-1:0];
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q - STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // Datapath, no reset
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = acc_q;
  assign rsp_o.remainder = rem_q;

endmodule

### rtl/binary_to_radix_digit_string.sv
// Channel | Direction | Handshake               | Payload
// in      | sink      | in_valid_i/in_ready_o   | value_i[62:0], radix_i[5:0]
// out     | source    | out_valid_o/out_ready_i | digit_char_o[6:0], last_digit_o
//
// Each digit costs one pass of the shared bit-serial divider (load, 63 steps,
// handoff). Output then reads each digit from the digit store and sends it as a
// beat; in_ready_o is low from acceptance until the last digit beat is taken.
// Reset clears the sequencer and digit count; the digit store needs no clearing.
// A stalled out beat holds; the divider sits idle meanwhile.
module binary_to_radix_digit_string import b2r_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [INPUT_WIDTH-1:0] value_i,
  input  logic [RADIX_W-1:0]     radix_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [CHAR_W-1:0]      digit_char_o,
  output logic                   last_digit_o
);

`include "binary_to_radix_digit_string_assert.svh"

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_START = 5'b00010,
    S_WAIT  = 5'b00100,
    S_READ  = 5'b01000,
    S_OUT   = 5'b10000
  } state_e;

  state_e                 state_q, state_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [IDX_W-1:0]       rd_idx_q, rd_idx_d;
  logic [VALUE_WIDTH-1:0] quo_q, quo_d;
  logic [RADIX_W-1:0]     radix_q, radix_d;
  logic [RADIX_W-1:0]     rdata_q;
  logic [RADIX_W-1:0]     digit_store [DIGIT_SLOTS];
  logic                   wr_en;
  logic                   has_room;
  logic [CNT_W-1:0]       count_next;
  logic [RADIX_W-1:0]     radix_sat;
  div_req_t               div_req;
  div_rsp_t               div_rsp;

  // Radix saturation
  always_comb begin
    radix_sat = radix_i;
    if (radix_i < RADIX_MIN) begin
      radix_sat = RADIX_MIN;
    end else if (radix_i > RADIX_MAX) begin
      radix_sat = RADIX_MAX;
    end
  end

  b2r_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign div_req.start    = (state_q == S_START);
  assign div_req.dividend = quo_q;
  assign div_req.divisor  = radix_q;

  // Digits beyond the store are dropped
  assign has_room   = count_q < CNT_W'(DIGIT_SLOTS);
  assign count_next = has_room ? count_q + CNT_W'(1) : count_q;
  assign wr_en      = (state_q == S_WAIT) && div_rsp.done && has_room;

  // Sequencer
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    rd_idx_d = rd_idx_q;
    quo_d    = quo_q;
    radix_d  = radix_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          quo_d   = value_i[VALUE_WIDTH-1:0];
          radix_d = radix_sat;
          count_d = '0;
          state_d = S_START;
        end
      end
      S_START: begin
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (div_rsp.done) begin
          count_d = count_next;
          quo_d   = div_rsp.quotient;
          if (div_rsp.quotient == '0) begin
            rd_idx_d = IDX_W'(count_next - CNT_W'(1));
            state_d  = S_READ;
          end else begin
            state_d = S_START;
          end
        end
      end
      S_READ: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) begin
          if (rd_idx_q == '0) begin
            state_d = S_IDLE;
          end else begin
            rd_idx_d = rd_idx_q - IDX_W'(1);
            state_d  = S_READ;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      rd_idx_q <= '0;
      quo_q    <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rd_idx_q <= rd_idx_d;
      quo_q    <= quo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    radix_q <= radix_d;
  end

  // Digit store: one write port, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      digit_store[count_q[IDX_W-1:0]] <= div_rsp.remainder;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_READ) begin
      rdata_q <= digit_store[rd_idx_q];
    end
  end

  // Output beat
  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = (state_q == S_OUT);
  assign digit_char_o = digit_to_ascii(rdata_q);
  assign last_digit_o = (rd_idx_q == '0);

  `B2R_ASSERT(a_count_bound, count_q <= CNT_W'(DIGIT_SLOTS), "digit count past store size")
  `B2R_ASSERT_IMPL(a_done_in_wait, div_rsp.done, state_q == S_WAIT, "divider done outside wait")
  `B2R_ASSERT_IMPL(a_last_frees, out_valid_o && out_ready_i && last_digit_o, ##1 in_ready_o,
                   "not ready after last digit beat")
  `B2R_ASSERT_IMPL(a_out_has_digit, out_valid_o, count_q != '0, "digit beat with empty store")
  `B2R_ASSERT_IMPL(a_digit_range, out_valid_o, rdata_q < radix_q, "digit not below radix")

endmodule
